// ===== rtl/sitbd_pkg.sv =====
// Shared types, constants and helpers for the signed integer to digit string converter.
`default_nettype none

package sitbd_pkg;

	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int BASE_W      = 5;
	localparam int WORD_W      = 64;
	localparam int SYM_SLOTS   = 16;
	localparam int DIG_W       = 4;
	localparam int DIGS_MAX    = 32;
	localparam int CNT_W       = 6;
	localparam int PTR_W       = 5;
	localparam int CFG_IDX_W   = 2;
	// Quotient bits settled per divider cycle, and divider steps per digit.
	localparam int DIV_BITS    = 8;
	localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
	localparam int STEP_W      = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [BASE_W-1:0] base_size;
		logic [WORD_W-1:0] digits_low;
		logic [WORD_W-1:0] digits_high;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	function automatic logic [CHAR_W-1:0] symbol_at(input cfg_t c, input logic [DIG_W-1:0] idx);
		logic [WORD_W-1:0] word;
		word = idx[3] ? c.digits_high : c.digits_low;
		return word[{idx[2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_base_digits.sv =====
// Top level of the signed integer to digit string converter.
`default_nettype none

// Converts each signed 32-bit input beat into its characters, most significant
// first, written with a configured alphabet of base_size symbols (radix 2 to
// 16): a leading '-' for negative numbers, the most negative value taken as
// magnitude 2147483648, tlast on the final character. When the alphabet is
// invalid (fewer than two symbols, radix above 16 or MAX_BASE, a used symbol
// that is zero, '+' or '-', or two equal used symbols) the number is accepted
// and dropped with no output. A front stage registers the beat, checks the
// alphabet and forms sign and magnitude; a two-entry queue hands numbers to
// the back stage, which divides by the radix eight quotient bits per cycle,
// then streams one character per cycle, while the output is not stalled,
// through an output register. A number has up to 32 digits (e.g. 10 for a
// full decimal value); the back stage takes the next number only once the
// last character of the previous one is in the output register. The front keeps
// accepting while the queue has room. Configuration writes are always taken
// and must happen only while the block is idle; index 3 is ignored.

module signed_int_to_base_digits #(
	parameter int MAX_BASE = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [sitbd_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [sitbd_pkg::CHAR_W-1:0]         m_axis_tdata,  // [7:0] char_code
	output logic                                 m_axis_tlast,  // last_char
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [sitbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [sitbd_pkg::WORD_W-1:0]         cfg_data
);

	sitbd_pkg::cfg_t  cfg_q;
	logic             push_valid;
	logic             push_ready;
	sitbd_pkg::item_t push_item;
	logic             pop_valid;
	logic             pop_ready;
	sitbd_pkg::item_t pop_item;

	assign cfg_ready = 1'b1;

	// Register file: radix and the two symbol words, all clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sitbd_pkg::CFG_BASE_SIZE: begin
					cfg_q.base_size <= cfg_data[sitbd_pkg::BASE_W-1:0];
				end
				sitbd_pkg::CFG_DIGITS_LOW: begin
					cfg_q.digits_low <= cfg_data;
				end
				sitbd_pkg::CFG_DIGITS_HIGH: begin
					cfg_q.digits_high <= cfg_data;
				end
				default: begin
					// Unused index: drop the write.
				end
			endcase
		end
	end

	sitbd_front #(
		.MAX_BASE(MAX_BASE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	sitbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	sitbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_char (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/sitbd_front.sv =====
// Front stage: takes input beats, checks the alphabet, splits sign and magnitude.
`default_nettype none

module sitbd_front #(
	parameter int MAX_BASE = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  sitbd_pkg::cfg_t            cfg,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [sitbd_pkg::VALUE_W-1:0]    in_value,
	output logic                             push_valid,
	input  wire                              push_ready,
	output sitbd_pkg::item_t                 push_item
);

	logic [sitbd_pkg::CHAR_W-1:0] sym [sitbd_pkg::SYM_SLOTS];
	logic                         alpha_ok;
	logic                         accept;
	logic                         v_s1_q;
	sitbd_pkg::item_t             item_s1;

	always_comb begin
		alpha_ok = (cfg.base_size >= 5'd2) && (cfg.base_size <= 5'(sitbd_pkg::SYM_SLOTS))
			&& ({27'd0, cfg.base_size} <= 32'(MAX_BASE));
		for (int i = 0; i < sitbd_pkg::SYM_SLOTS; i++) begin
			sym[i] = sitbd_pkg::symbol_at(cfg, 4'(i));
		end
		for (int i = 0; i < sitbd_pkg::SYM_SLOTS; i++) begin
			if (5'(i) < cfg.base_size) begin
				if (sym[i] == 8'h00 || sym[i] == sitbd_pkg::CH_PLUS
						|| sym[i] == sitbd_pkg::CH_MINUS) begin
					alpha_ok = 1'b0;
				end
				for (int j = 0; j < i; j++) begin
					if (sym[i] == sym[j]) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

	assign in_ready   = !v_s1_q || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = v_s1_q;
	assign push_item  = item_s1;

	// Drop the beat outright when the alphabet is bad: nothing is emitted for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept) begin
			v_s1_q <= alpha_ok;
		end else if (push_ready) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.neg <= in_value[sitbd_pkg::VALUE_W-1];
			item_s1.mag <= in_value[sitbd_pkg::VALUE_W-1]
				? (sitbd_pkg::VALUE_W'(0) - in_value) : in_value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sitbd_fifo.sv =====
// Short queue of classified numbers between the front and back stages.
`default_nettype none

module sitbd_fifo (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push_valid,
	output logic                   push_ready,
	input  wire  sitbd_pkg::item_t push_item,
	output logic                   pop_valid,
	input  wire                    pop_ready,
	output sitbd_pkg::item_t       pop_item
);

	sitbd_pkg::item_t                mem_q [sitbd_pkg::QUEUE_DEPTH];
	logic [sitbd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sitbd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sitbd_pkg::QCNT_W-1:0]    count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != sitbd_pkg::QCNT_W'(sitbd_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sitbd_back.sv =====
// Back stage: digit extraction by iterative division, then character output.
`default_nettype none

module sitbd_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  sitbd_pkg::cfg_t          cfg,
	input  wire                            pop_valid,
	output logic                           pop_ready,
	input  wire  sitbd_pkg::item_t         pop_item,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [sitbd_pkg::CHAR_W-1:0]   out_char,
	output logic                           out_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t                          state_q;
	logic [sitbd_pkg::VALUE_W-1:0]   quo_q;
	logic [sitbd_pkg::DIG_W-1:0]     rem_q;
	logic [sitbd_pkg::STEP_W-1:0]    step_q;
	logic [sitbd_pkg::CNT_W-1:0]     nd_q;
	logic [sitbd_pkg::PTR_W-1:0]     ptr_q;
	logic                            neg_q;
	logic [sitbd_pkg::DIG_W-1:0]     dig_q [sitbd_pkg::DIGS_MAX];
	logic                            out_valid_q;
	logic [sitbd_pkg::CHAR_W-1:0]    out_char_q;
	logic                            out_last_q;

	logic [sitbd_pkg::VALUE_W-1:0]   quo_next;
	logic [sitbd_pkg::DIG_W-1:0]     rem_next;
	logic [sitbd_pkg::DIV_BITS-1:0]  qbits;
	logic [sitbd_pkg::DIG_W:0]       trial;
	logic                            digit_done;
	logic                            div_last;
	logic                            out_load;
	logic [sitbd_pkg::CHAR_W-1:0]    char_d;
	logic                            last_d;

	// Restoring division by the radix, eight quotient bits per cycle. The
	// partial remainder stays below the radix, so it fits four bits.
	always_comb begin
		rem_next = rem_q;
		qbits    = '0;
		for (int i = 0; i < sitbd_pkg::DIV_BITS; i++) begin
			trial = {rem_next, quo_q[sitbd_pkg::VALUE_W-1-i]};
			if (trial >= cfg.base_size) begin
				trial = trial - cfg.base_size;
				qbits[sitbd_pkg::DIV_BITS-1-i] = 1'b1;
			end
			rem_next = trial[sitbd_pkg::DIG_W-1:0];
		end
		quo_next = {quo_q[sitbd_pkg::VALUE_W-sitbd_pkg::DIV_BITS-1:0], qbits};
	end

	assign digit_done = (state_q == ST_DIV)
		&& (step_q == sitbd_pkg::STEP_W'(sitbd_pkg::DIV_STEPS - 1));
	assign div_last   = (quo_next == '0)
		|| (nd_q == sitbd_pkg::CNT_W'(sitbd_pkg::DIGS_MAX - 1));

	always_comb begin
		if (state_q == ST_SIGN) begin
			char_d = sitbd_pkg::CH_MINUS;
			last_d = 1'b0;
		end else begin
			char_d = sitbd_pkg::symbol_at(cfg, dig_q[ptr_q]);
			last_d = ptr_q == '0;
		end
	end

	assign out_load  = ((state_q == ST_SIGN) || (state_q == ST_DIGIT))
		&& (!out_valid_q || out_ready);
	assign pop_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			nd_q        <= '0;
			ptr_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_char_q  <= char_d;
				out_last_q  <= last_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						quo_q   <= pop_item.mag;
						neg_q   <= pop_item.neg;
						rem_q   <= '0;
						step_q  <= '0;
						nd_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (digit_done) begin
						rem_q <= '0;
						nd_q  <= nd_q + 1'b1;
						if (div_last) begin
							ptr_q   <= nd_q[sitbd_pkg::PTR_W-1:0];
							state_q <= neg_q ? ST_SIGN : ST_DIGIT;
						end
					end else begin
						rem_q <= rem_next;
					end
				end
				ST_SIGN: begin
					if (out_load) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_load) begin
						if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Store each remainder as it is produced, least significant digit first.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			dig_q[nd_q[sitbd_pkg::PTR_W-1:0]] <= rem_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sitbd_checker.sv =====
// Port-level checks on the converter's output stream, bound to the top level.
`default_nettype none

module sitbd_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [sitbd_pkg::CHAR_W-1:0]      m_axis_tdata,
	input wire                              m_axis_tlast
);

	// Hold a stalled beat unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// A valid alphabet never holds zero or '+', so neither may appear.
	a_no_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != 8'h00) && (m_axis_tdata != sitbd_pkg::CH_PLUS))
		else $error("output character is zero or plus");

	// The sign always precedes digits, so it never closes a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata == sitbd_pkg::CH_MINUS) |-> !m_axis_tlast)
		else $error("minus sign marked as last character");

	// A sign beat is followed by a digit, never by another sign.
	a_single_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tdata == sitbd_pkg::CH_MINUS) |=>
			!(m_axis_tvalid && (m_axis_tdata == sitbd_pkg::CH_MINUS)))
		else $error("two sign characters in a row");

endmodule

bind signed_int_to_base_digits sitbd_checker u_checker (.*);

`default_nettype wire
